// ----- rtl/sptx_pkg.sv -----
package sptx_pkg;

    // Opcode and prefix bytes that appear in the table.
    localparam logic [7:0] OP_PACKAGE  = 8'h12;
    localparam logic [7:0] OP_BYTE     = 8'h0A;
    localparam logic [7:0] OP_WORD     = 8'h0B;
    localparam logic [7:0] OP_DWORD    = 8'h0C;
    localparam logic [7:0] OP_ZERO     = 8'h00;
    localparam logic [7:0] OP_ONE      = 8'h01;
    localparam logic [7:0] NAME_MARK   = 8'h5F;

    // Offsets and limits.
    localparam logic [31:0] MIN_OPCODE_POS = 32'd40;
    localparam logic [31:0] MIN_TABLE_LEN  = 32'd44;
    localparam logic [32:0] OPCODE_MARGIN  = 33'd12;
    localparam logic [31:0] LEN_LAST_POS   = 32'd7;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHAR_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHAR_SECOND = 1'b1;

    localparam logic [7:0] NAME_CHAR_FIRST_RESET  = 8'd83;
    localparam logic [7:0] NAME_CHAR_SECOND_RESET = 8'd53;

    typedef struct packed {
        logic       found;
        logic [7:0] sleep_type_a;
        logic [7:0] sleep_type_b;
    } result_t;

endpackage

// ----- rtl/sptx_if.sv -----
interface sptx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] table_byte;
    logic       last_byte;

    modport source (output valid, output table_byte, output last_byte, input ready);
    modport sink   (input valid, input table_byte, input last_byte, output ready);
endinterface

interface sptx_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] sleep_type_a;
    logic [7:0] sleep_type_b;

    modport source (output valid, output found, output sleep_type_a, output sleep_type_b,
                    input ready);
    modport sink   (input valid, input found, input sleep_type_a, input sleep_type_b,
                    output ready);
endinterface

interface sptx_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] reg_index;
    logic [7:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ----- rtl/sptx_out_skid.sv -----
module sptx_out_skid
    import sptx_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  result_t         push_data,
    output logic            push_ready,
    sptx_result_if.source   res
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    // Space is offered as long as the spare slot is free, so the upstream
    // ready never depends on the downstream ready in the same cycle.
    assign push_ready = !skid_valid_reg;
    assign pop        = out_valid_reg && res.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.found        = out_data_reg.found;
    assign res.sleep_type_a = out_data_reg.sleep_type_a;
    assign res.sleep_type_b = out_data_reg.sleep_type_b;

    // The spare slot is only ever filled behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds an item while the output is empty");

    // A pop with a full spare slot moves that item forward.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid item lost on output pop");

    // A waiting output item stays put until the receiver takes it.
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("output item changed while stalled");

endmodule

// ----- rtl/sleep_package_type_extractor.sv -----
// Sleep package type extractor.
//
// The table arrives on the tbl channel, one byte per item starting at offset
// zero, with last_byte set on the final byte. The block picks up the table
// length from bytes 4..7, finds the package named '_' X Y '_' (the two
// middle characters come from the configuration registers) and decodes the
// first two integers of that package into sleep_type_a and sleep_type_b.
// Exactly one item per table leaves on the res channel: either when the
// decision is made, or with found = 0 at the last byte if none was made.
//
// Each byte is handled in the cycle it is accepted; one item is accepted per
// cycle while tbl.ready is high, through the single byte-wide decode path.
// A result passes through the output register before it appears on res.
// The res channel is fronted by an output register plus a one-item skid slot:
// while a result waits, bytes keep flowing, and tbl.ready drops only once a
// second result is waiting behind a stalled receiver.
// Reset clears the parse state and loads the name characters 'S' and '5'.
// Configuration writes are always taken (cfg.ready is high) and should be
// made only while no table is in flight.
module sleep_package_type_extractor
    import sptx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sptx_byte_if.sink     tbl,
    sptx_result_if.source res,
    sptx_cfg_if.sink      cfg
);

    localparam logic [3:0] PH_SEARCH  = 4'd0;
    localparam logic [3:0] PH_PKGLEN  = 4'd1;
    localparam logic [3:0] PH_LENSKIP = 4'd2;
    localparam logic [3:0] PH_COUNT   = 4'd3;
    localparam logic [3:0] PH_A_OP    = 4'd4;
    localparam logic [3:0] PH_A_DATA  = 4'd5;
    localparam logic [3:0] PH_A_SKIP  = 4'd6;
    localparam logic [3:0] PH_B_OP    = 4'd7;
    localparam logic [3:0] PH_B_DATA  = 4'd8;
    localparam logic [3:0] PH_DONE    = 4'd9;

    logic [7:0]  name_char_first_reg;
    logic [7:0]  name_char_second_reg;

    logic [31:0] byte_position_reg;
    logic [31:0] byte_position_next;
    logic [31:0] table_length_reg;
    logic [31:0] table_length_next;
    logic [31:0] name_window_reg;
    logic [31:0] name_window_next;
    logic [3:0]  parse_phase_reg;
    logic [3:0]  parse_phase_next;
    logic [2:0]  skip_remaining_reg;
    logic [2:0]  skip_remaining_next;
    logic [7:0]  first_type_reg;
    logic [7:0]  first_type_next;
    logic        decision_made_reg;
    logic        decision_made_next;

    logic        in_fire;
    logic        push_ready;
    logic        push_valid;
    result_t     push_data;
    logic [7:0]  b;
    logic        name_hit;
    logic        is_small_const;
    logic        is_prefix;

    assign in_fire   = tbl.valid && tbl.ready;
    assign tbl.ready = push_ready;
    assign cfg.ready = 1'b1;
    assign b         = tbl.table_byte;

    assign is_small_const = (b == OP_ZERO) || (b == OP_ONE);
    assign is_prefix      = (b == OP_BYTE) || (b == OP_WORD) || (b == OP_DWORD);

    // The window holds the four bytes before this one, oldest on top; this
    // byte must then be the package opcode.
    assign name_hit = (byte_position_reg >= MIN_OPCODE_POS)
                   && (({1'b0, byte_position_reg} + OPCODE_MARGIN)
                       < {1'b0, table_length_reg})
                   && (name_window_reg[31:24] == NAME_MARK)
                   && (name_window_reg[23:16] == name_char_first_reg)
                   && (name_window_reg[15:8]  == name_char_second_reg)
                   && (name_window_reg[7:0]   == NAME_MARK)
                   && (b == OP_PACKAGE);

    always_comb
    begin
        byte_position_next  = byte_position_reg;
        table_length_next   = table_length_reg;
        parse_phase_next    = parse_phase_reg;
        skip_remaining_next = skip_remaining_reg;
        first_type_next     = first_type_reg;
        decision_made_next  = decision_made_reg;
        push_valid          = 1'b0;
        push_data           = '0;

        if (!decision_made_reg)
        begin
            // Length bytes are little-endian at offsets 4 through 7.
            if (byte_position_reg[31:2] == 30'd1)
            begin
                case (byte_position_reg[1:0])
                    2'd0:    table_length_next = table_length_reg | {24'd0, b};
                    2'd1:    table_length_next = table_length_reg | {16'd0, b, 8'd0};
                    2'd2:    table_length_next = table_length_reg | {8'd0, b, 16'd0};
                    default: table_length_next = table_length_reg | {b, 24'd0};
                endcase
            end

            unique case (parse_phase_reg) inside
                PH_SEARCH:
                begin
                    if (byte_position_reg == LEN_LAST_POS
                        && table_length_next < MIN_TABLE_LEN)
                    begin
                        push_valid = 1'b1;
                    end
                    else if (name_hit)
                    begin
                        parse_phase_next = PH_PKGLEN;
                    end
                end
                PH_PKGLEN:
                begin
                    // Lead byte bits 7:6 give the number of extra length bytes.
                    skip_remaining_next = {1'b0, b[7:6]};
                    parse_phase_next = (b[7:6] != 2'd0) ? PH_LENSKIP : PH_COUNT;
                end
                PH_LENSKIP, PH_A_SKIP:
                begin
                    skip_remaining_next = skip_remaining_reg - 3'd1;
                    if (skip_remaining_next == 3'd0)
                    begin
                        parse_phase_next =
                            (parse_phase_reg == PH_LENSKIP) ? PH_COUNT : PH_B_OP;
                    end
                end
                PH_COUNT:
                begin
                    parse_phase_next = PH_A_OP;
                end
                PH_A_OP:
                begin
                    if (is_small_const)
                    begin
                        first_type_next  = b;
                        parse_phase_next = PH_B_OP;
                    end
                    else if (is_prefix)
                    begin
                        skip_remaining_next = (b == OP_WORD)  ? 3'd1 :
                                              (b == OP_DWORD) ? 3'd3 : 3'd0;
                        parse_phase_next    = PH_A_DATA;
                    end
                    else
                    begin
                        push_valid = 1'b1;
                    end
                end
                PH_A_DATA:
                begin
                    first_type_next  = b;
                    parse_phase_next = (skip_remaining_reg != 3'd0) ? PH_A_SKIP : PH_B_OP;
                end
                PH_B_OP:
                begin
                    if (is_prefix)
                    begin
                        parse_phase_next = PH_B_DATA;
                    end
                    else
                    begin
                        // A bad second integer repeats the first one.
                        push_valid             = 1'b1;
                        push_data.found        = 1'b1;
                        push_data.sleep_type_a = first_type_reg;
                        push_data.sleep_type_b = is_small_const ? b : first_type_reg;
                    end
                end
                PH_B_DATA:
                begin
                    push_valid             = 1'b1;
                    push_data.found        = 1'b1;
                    push_data.sleep_type_a = first_type_reg;
                    push_data.sleep_type_b = b;
                end
                default:
                begin
                end
            endcase
        end

        if (push_valid)
        begin
            decision_made_next = 1'b1;
            parse_phase_next   = PH_DONE;
        end

        name_window_next = {name_window_reg[23:0], b};
        if (byte_position_reg != '1)
        begin
            byte_position_next = byte_position_reg + 32'd1;
        end

        if (tbl.last_byte)
        begin
            // Undecided table: report not found, then start over.
            if (!push_valid && !decision_made_reg)
            begin
                push_valid = 1'b1;
                push_data  = '0;
            end
            byte_position_next  = '0;
            table_length_next   = '0;
            name_window_next    = '0;
            parse_phase_next    = PH_SEARCH;
            skip_remaining_next = '0;
            first_type_next     = '0;
            decision_made_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= '0;
            table_length_reg   <= '0;
            name_window_reg    <= '0;
            parse_phase_reg    <= PH_SEARCH;
            skip_remaining_reg <= '0;
            first_type_reg     <= '0;
            decision_made_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            byte_position_reg  <= byte_position_next;
            table_length_reg   <= table_length_next;
            name_window_reg    <= name_window_next;
            parse_phase_reg    <= parse_phase_next;
            skip_remaining_reg <= skip_remaining_next;
            first_type_reg     <= first_type_next;
            decision_made_reg  <= decision_made_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_char_first_reg  <= NAME_CHAR_FIRST_RESET;
            name_char_second_reg <= NAME_CHAR_SECOND_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                CFG_NAME_CHAR_FIRST:  name_char_first_reg  <= cfg.reg_data;
                CFG_NAME_CHAR_SECOND: name_char_second_reg <= cfg.reg_data;
                default:
                begin
                end
            endcase
        end
    end

    sptx_out_skid u_out_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_fire && push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .res        (res)
    );

    // A decided table sits in the done phase until its last byte.
    a_decided_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        decision_made_reg |-> (parse_phase_reg == PH_DONE))
        else $error("decision flag set outside the done phase");

    // Skip phases are entered only with bytes left to skip.
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((parse_phase_reg == PH_LENSKIP) || (parse_phase_reg == PH_A_SKIP))
        |-> (skip_remaining_reg != 3'd0))
        else $error("skip phase with nothing left to skip");

    // The phase never leaves the defined set of codes.
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        parse_phase_reg <= PH_DONE)
        else $error("parse phase outside the defined codes");

endmodule
